/* rtl/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, codes and the CRC-32 byte step for the stream cipher unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcc_pkg;

   localparam int MAX_TABLE_DEFAULT = 256;

   localparam logic [1:0] MODE_KEY     = 2'd0;
   localparam logic [1:0] MODE_ENCRYPT = 2'd1;
   localparam logic [1:0] MODE_DECRYPT = 2'd2;
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_KEY    = 2'd1;
   localparam logic [1:0] STATUS_CRC_BAD   = 2'd2;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd3;

   localparam logic [1:0] SIZE_NONE = 2'd0;
   localparam logic [1:0] SIZE_64   = 2'd1;
   localparam logic [1:0] SIZE_128  = 2'd2;
   localparam logic [1:0] SIZE_256  = 2'd3;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KS_INIT,
      ST_KS_RD_I,
      ST_KS_RD_J,
      ST_KS_WR_I,
      ST_KS_WR_J,
      ST_COPY,
      ST_KG_RD_I,
      ST_KG_RD_J,
      ST_KG_WR_I,
      ST_KG_WR_J,
      ST_KG_RD_T,
      ST_KG_USE,
      ST_NO_KEY
   } state_type;

   // Reflected CRC-32 update by one byte, one bit per step.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* rtl/rcc_table_ram.sv */
// ----------------------------------------------------------------------------
// rcc_table_ram
// Byte-wide memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcc_table_ram #(
   parameter int DEPTH = rcc_pkg::MAX_TABLE_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rc4_crc_stream_cipher_unit.sv */
// ----------------------------------------------------------------------------
// rc4_crc_stream_cipher_unit
// RC4-style stream cipher with a CRC-32 trailer on tables with one read and one write port each.
// ----------------------------------------------------------------------------
// Key bytes (tuser mode 0) are stored one per transfer; the transfer with
// tlast set ends the key, and a key of 64, 128 or 256 bytes (at most
// MAX_TABLE) runs the key schedule, which first initializes the master
// table and then mixes it. After its accepting cycle, each message byte
// passes through the one shared read port of the work table in steps
// (read S[i], read S[j], two swap writes, read S[t], combine), and may
// wait for the result side. The first byte of a message first copies the
// master table into the work table. An encrypted last byte adds four more
// keystream steps for the appended CRC bytes, low byte first. Decryption
// holds back four bytes and reports the CRC verdict on the final result.
// The unit takes one request transfer at a time and is not ready while it
// works; a finished result waits in an output register. There is no
// clearing pass after reset: the tables are only read after being written.
`timescale 1ns / 1ps

module rc4_crc_stream_cipher_unit #(
   parameter int MAX_TABLE = rcc_pkg::MAX_TABLE_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] data_byte
   input  logic [1:0] req_tuser,  // [1:0] mode
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] result_byte
   output logic [2:0] rsp_tuser,  // [0] is_crc_byte, [2:1] status
   output logic       rsp_tlast
);

   localparam int AW = $clog2(MAX_TABLE);
   localparam int CW = AW + 1;

   rcc_pkg::state_type state_ff, state_in;

   logic [7:0]    data_ff, data_in;
   logic          last_ff, last_in;
   logic [8:0]    key_count_ff, key_count_in;
   logic [1:0]    size_code_ff, size_code_in;
   logic          key_valid_ff, key_valid_in;
   logic [AW-1:0] index_i_ff, index_i_in;
   logic [AW-1:0] index_j_ff, index_j_in;
   logic          in_message_ff, in_message_in;
   logic          decrypt_ff, decrypt_in;
   logic [31:0]   crc_ff, crc_in;
   logic [31:0]   delay_ff, delay_in;
   logic [2:0]    msg_count_ff, msg_count_in;
   logic          trailer_ff, trailer_in;
   logic [1:0]    trail_count_ff, trail_count_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    val_a_ff, val_a_in;
   logic [7:0]    val_b_ff, val_b_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_crc_ff, rsp_crc_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [1:0] rsp_status_ff, rsp_status_in;

   logic          m_we, w_we, k_we, m_re, w_re, k_re;
   logic [AW-1:0] m_wa, w_wa, k_wa, m_ra, w_ra, k_ra;
   logic [7:0]    m_wd, w_wd, k_wd, m_rd, w_rd, k_rd;

   logic          req_accept;
   logic          out_free;
   logic [9:0]    key_len;
   logic [1:0]    len_code;
   logic          len_valid;
   logic [8:0]    size_n9;
   logic [CW-1:0] table_n;
   logic [AW-1:0] mask;
   logic          count_last;
   logic          release_byte;
   logic          need_emit;
   logic          proceed;

   rcc_table_ram #(.DEPTH(MAX_TABLE), .AW(AW)) u_master (
      .clock(clock), .wr_en(m_we), .wr_addr(m_wa), .wr_data(m_wd),
      .rd_en(m_re), .rd_addr(m_ra), .rd_data(m_rd)
   );

   rcc_table_ram #(.DEPTH(MAX_TABLE), .AW(AW)) u_work (
      .clock(clock), .wr_en(w_we), .wr_addr(w_wa), .wr_data(w_wd),
      .rd_en(w_re), .rd_addr(w_ra), .rd_data(w_rd)
   );

   rcc_table_ram #(.DEPTH(MAX_TABLE), .AW(AW)) u_key (
      .clock(clock), .wr_en(k_we), .wr_addr(k_wa), .wr_data(k_wd),
      .rd_en(k_re), .rd_addr(k_ra), .rd_data(k_rd)
   );

   assign req_tready = (state_ff == rcc_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Key length decode: only 64, 128 and 256 bytes make a usable key.
   assign key_len  = {1'b0, key_count_ff} + 10'd1;
   assign len_code = (key_len == 10'd64)  ? rcc_pkg::SIZE_64  :
                     (key_len == 10'd128) ? rcc_pkg::SIZE_128 :
                     (key_len == 10'd256) ? rcc_pkg::SIZE_256 : rcc_pkg::SIZE_NONE;
   assign len_valid = (len_code != rcc_pkg::SIZE_NONE) && (key_len <= 10'(MAX_TABLE));

   // Table size N and the index mask N-1 follow the stored size code.
   assign size_n9    = 9'd32 << size_code_ff;
   assign table_n    = size_n9[CW-1:0];
   assign mask       = AW'(size_n9 - 9'd1);
   assign count_last = (count_ff == table_n - CW'(1));

   // Decrypt releases the byte four places back once four are held.
   assign release_byte = (msg_count_ff >= 3'd4);
   assign need_emit    = !decrypt_ff || trailer_ff || last_ff || release_byte;
   assign proceed      = !need_emit || out_free;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcc_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == rcc_pkg::MODE_KEY) begin
                  if (req_tlast && len_valid) begin
                     state_in = rcc_pkg::ST_KS_INIT;
                  end
               end else if (req_tuser != rcc_pkg::MODE_IGNORED) begin
                  if (!key_valid_ff) begin
                     state_in = rcc_pkg::ST_NO_KEY;
                  end else if (!in_message_ff) begin
                     state_in = rcc_pkg::ST_COPY;
                  end else begin
                     state_in = rcc_pkg::ST_KG_RD_I;
                  end
               end
            end
         end
         rcc_pkg::ST_KS_INIT: begin
            if (count_last) begin
               state_in = rcc_pkg::ST_KS_RD_I;
            end
         end
         rcc_pkg::ST_KS_RD_I: state_in = rcc_pkg::ST_KS_RD_J;
         rcc_pkg::ST_KS_RD_J: state_in = rcc_pkg::ST_KS_WR_I;
         rcc_pkg::ST_KS_WR_I: state_in = rcc_pkg::ST_KS_WR_J;
         rcc_pkg::ST_KS_WR_J: begin
            state_in = count_last ? rcc_pkg::ST_IDLE : rcc_pkg::ST_KS_RD_I;
         end
         rcc_pkg::ST_COPY: begin
            if (count_ff == table_n) begin
               state_in = rcc_pkg::ST_KG_RD_I;
            end
         end
         rcc_pkg::ST_KG_RD_I: state_in = rcc_pkg::ST_KG_RD_J;
         rcc_pkg::ST_KG_RD_J: state_in = rcc_pkg::ST_KG_WR_I;
         rcc_pkg::ST_KG_WR_I: state_in = rcc_pkg::ST_KG_WR_J;
         rcc_pkg::ST_KG_WR_J: state_in = rcc_pkg::ST_KG_RD_T;
         rcc_pkg::ST_KG_RD_T: state_in = rcc_pkg::ST_KG_USE;
         rcc_pkg::ST_KG_USE: begin
            if (proceed) begin
               if (!decrypt_ff && !trailer_ff && last_ff) begin
                  state_in = rcc_pkg::ST_KG_RD_I;
               end else if (trailer_ff && trail_count_ff != 2'd3) begin
                  state_in = rcc_pkg::ST_KG_RD_I;
               end else begin
                  state_in = rcc_pkg::ST_IDLE;
               end
            end
         end
         rcc_pkg::ST_NO_KEY: begin
            if (out_free) begin
               state_in = rcc_pkg::ST_IDLE;
            end
         end
         default: state_in = rcc_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory ports and result register loading.
   always_comb begin
      logic        emit;
      logic [7:0]  e_byte;
      logic        e_crc;
      logic        e_last;
      logic [1:0]  e_status;
      logic [31:0] crc_new;
      logic [31:0] delay_new;
      logic [31:0] crc_final;
      logic [9:0]  sum_j;

      emit     = 1'b0;
      e_byte   = 8'd0;
      e_crc    = 1'b0;
      e_last   = 1'b0;
      e_status = rcc_pkg::STATUS_OK;
      crc_new  = crc_ff;
      delay_new = delay_ff;
      crc_final = ~crc_ff;
      sum_j    = 10'd0;

      data_in        = data_ff;
      last_in        = last_ff;
      key_count_in   = key_count_ff;
      size_code_in   = size_code_ff;
      key_valid_in   = key_valid_ff;
      index_i_in     = index_i_ff;
      index_j_in     = index_j_ff;
      in_message_in  = in_message_ff;
      decrypt_in     = decrypt_ff;
      crc_in         = crc_ff;
      delay_in       = delay_ff;
      msg_count_in   = msg_count_ff;
      trailer_in     = trailer_ff;
      trail_count_in = trail_count_ff;
      count_in       = count_ff;
      val_a_in       = val_a_ff;
      val_b_in       = val_b_ff;

      m_we = 1'b0; m_wa = '0; m_wd = 8'd0; m_re = 1'b0; m_ra = '0;
      w_we = 1'b0; w_wa = '0; w_wd = 8'd0; w_re = 1'b0; w_ra = '0;
      k_we = 1'b0; k_wa = '0; k_wd = 8'd0; k_re = 1'b0; k_ra = '0;

      unique case (state_ff)
         rcc_pkg::ST_IDLE: begin
            if (req_accept) begin
               data_in = req_tdata;
               last_in = req_tlast;
               if (req_tuser == rcc_pkg::MODE_KEY) begin
                  in_message_in = 1'b0;
                  if (key_count_ff < 9'(MAX_TABLE)) begin
                     k_we = 1'b1;
                     k_wa = key_count_ff[AW-1:0];
                     k_wd = req_tdata;
                  end
                  if (req_tlast) begin
                     if (len_valid) begin
                        size_code_in = len_code;
                        key_valid_in = 1'b1;
                        count_in     = '0;
                        index_j_in   = '0;
                     end else begin
                        size_code_in = rcc_pkg::SIZE_NONE;
                        key_valid_in = 1'b0;
                     end
                     key_count_in = 9'd0;
                  end else if (key_count_ff != 9'd511) begin
                     key_count_in = key_count_ff + 9'd1;
                  end
               end else if (req_tuser != rcc_pkg::MODE_IGNORED && key_valid_ff &&
                            !in_message_ff) begin
                  // Fresh message: restart the cipher state and the CRC.
                  index_i_in     = '0;
                  index_j_in     = '0;
                  crc_in         = '1;
                  delay_in       = 32'd0;
                  msg_count_in   = 3'd0;
                  decrypt_in     = (req_tuser == rcc_pkg::MODE_DECRYPT);
                  in_message_in  = 1'b1;
                  trailer_in     = 1'b0;
                  trail_count_in = 2'd0;
                  count_in       = '0;
               end
            end
         end
         rcc_pkg::ST_KS_INIT: begin
            m_we     = 1'b1;
            m_wa     = count_ff[AW-1:0];
            m_wd     = 8'(count_ff[AW-1:0]);
            count_in = count_last ? '0 : count_ff + CW'(1);
         end
         rcc_pkg::ST_KS_RD_I: begin
            m_re = 1'b1;
            m_ra = count_ff[AW-1:0];
            k_re = 1'b1;
            k_ra = count_ff[AW-1:0];
         end
         rcc_pkg::ST_KS_RD_J: begin
            sum_j      = {2'd0, 8'(index_j_ff)} + {2'd0, m_rd} + {2'd0, k_rd};
            index_j_in = sum_j[AW-1:0] & mask;
            val_a_in   = m_rd;
            m_re       = 1'b1;
            m_ra       = sum_j[AW-1:0] & mask;
         end
         rcc_pkg::ST_KS_WR_I: begin
            m_we = 1'b1;
            m_wa = count_ff[AW-1:0];
            m_wd = m_rd;
         end
         rcc_pkg::ST_KS_WR_J: begin
            m_we     = 1'b1;
            m_wa     = index_j_ff;
            m_wd     = val_a_ff;
            count_in = count_ff + CW'(1);
         end
         rcc_pkg::ST_COPY: begin
            if (count_ff < table_n) begin
               m_re = 1'b1;
               m_ra = count_ff[AW-1:0];
            end
            if (count_ff != '0) begin
               w_we = 1'b1;
               w_wa = AW'(count_ff - CW'(1));
               w_wd = m_rd;
            end
            count_in = count_ff + CW'(1);
         end
         rcc_pkg::ST_KG_RD_I: begin
            index_i_in = (index_i_ff + AW'(1)) & mask;
            w_re       = 1'b1;
            w_ra       = (index_i_ff + AW'(1)) & mask;
         end
         rcc_pkg::ST_KG_RD_J: begin
            val_a_in   = w_rd;
            index_j_in = (index_j_ff + w_rd[AW-1:0]) & mask;
            w_re       = 1'b1;
            w_ra       = (index_j_ff + w_rd[AW-1:0]) & mask;
         end
         rcc_pkg::ST_KG_WR_I: begin
            val_b_in = w_rd;
            w_we     = 1'b1;
            w_wa     = index_i_ff;
            w_wd     = w_rd;
         end
         rcc_pkg::ST_KG_WR_J: begin
            w_we = 1'b1;
            w_wa = index_j_ff;
            w_wd = val_a_ff;
         end
         rcc_pkg::ST_KG_RD_T: begin
            w_re = 1'b1;
            w_ra = (val_a_ff[AW-1:0] + val_b_ff[AW-1:0]) & mask;
         end
         rcc_pkg::ST_KG_USE: begin
            if (proceed) begin
               if (trailer_ff) begin
                  // Appended CRC bytes, low byte first.
                  emit           = 1'b1;
                  e_byte         = crc_final[8*trail_count_ff +: 8] ^ w_rd;
                  e_crc          = 1'b1;
                  e_last         = (trail_count_ff == 2'd3);
                  trail_count_in = trail_count_ff + 2'd1;
                  if (trail_count_ff == 2'd3) begin
                     trailer_in    = 1'b0;
                     in_message_in = 1'b0;
                  end
               end else if (!decrypt_ff) begin
                  emit   = 1'b1;
                  e_byte = data_ff ^ w_rd;
                  crc_in = rcc_pkg::crc_byte(crc_ff, data_ff);
                  if (last_ff) begin
                     trailer_in     = 1'b1;
                     trail_count_in = 2'd0;
                  end
               end else begin
                  if (release_byte) begin
                     crc_new = rcc_pkg::crc_byte(crc_ff, delay_ff[7:0]);
                  end
                  delay_new = {data_ff ^ w_rd, delay_ff[31:8]};
                  crc_in    = crc_new;
                  delay_in  = delay_new;
                  if (msg_count_ff < 3'd4) begin
                     msg_count_in = msg_count_ff + 3'd1;
                  end
                  if (!last_ff) begin
                     emit   = release_byte;
                     e_byte = delay_ff[7:0];
                  end else begin
                     emit          = 1'b1;
                     e_last        = 1'b1;
                     in_message_in = 1'b0;
                     // Fewer than four bytes in all, this one included.
                     if (msg_count_ff < 3'd3) begin
                        e_status = rcc_pkg::STATUS_TOO_SHORT;
                     end else begin
                        e_byte   = release_byte ? delay_ff[7:0] : 8'd0;
                        e_status = (~crc_new == delay_new) ? rcc_pkg::STATUS_OK :
                                                             rcc_pkg::STATUS_CRC_BAD;
                     end
                  end
               end
            end
         end
         rcc_pkg::ST_NO_KEY: begin
            if (out_free) begin
               emit     = 1'b1;
               e_last   = last_ff;
               e_status = rcc_pkg::STATUS_NO_KEY;
            end
         end
         default: begin
         end
      endcase

      // The output register takes a new result only when free.
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_crc_in    = rsp_crc_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = e_byte;
         rsp_crc_in    = e_crc;
         rsp_last_in   = e_last;
         rsp_status_in = e_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rcc_pkg::ST_IDLE;
         key_count_ff   <= 9'd0;
         size_code_ff   <= rcc_pkg::SIZE_NONE;
         key_valid_ff   <= 1'b0;
         index_i_ff     <= '0;
         index_j_ff     <= '0;
         in_message_ff  <= 1'b0;
         decrypt_ff     <= 1'b0;
         crc_ff         <= '1;
         delay_ff       <= 32'd0;
         msg_count_ff   <= 3'd0;
         trailer_ff     <= 1'b0;
         trail_count_ff <= 2'd0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         key_count_ff   <= key_count_in;
         size_code_ff   <= size_code_in;
         key_valid_ff   <= key_valid_in;
         index_i_ff     <= index_i_in;
         index_j_ff     <= index_j_in;
         in_message_ff  <= in_message_in;
         decrypt_ff     <= decrypt_in;
         crc_ff         <= crc_in;
         delay_ff       <= delay_in;
         msg_count_ff   <= msg_count_in;
         trailer_ff     <= trailer_in;
         trail_count_ff <= trail_count_in;
         count_ff       <= count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff       <= data_in;
      last_ff       <= last_in;
      val_a_ff      <= val_a_in;
      val_b_ff      <= val_b_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_crc_ff    <= rsp_crc_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_crc_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/rcc_checker.sv */
// ----------------------------------------------------------------------------
// rcc_checker
// Port-level checks of the stream cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [1:0] req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A message byte always makes the unit busy in the cycle after it is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == rcc_pkg::MODE_ENCRYPT || req_tuser == rcc_pkg::MODE_DECRYPT)
      |=> !req_tready)
      else $error("ready right after a message byte");

   // Appended CRC bytes always carry an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tuser[2:1] == rcc_pkg::STATUS_OK)
      else $error("CRC byte with error status");

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rc4_crc_stream_cipher_unit rcc_checker u_rcc_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);

/* verif/rc4_crc_stream_cipher_unit_checker.sv */
// ----------------------------------------------------------------------------
// rc4_crc_stream_cipher_unit_checker
// Watches both streams of the cipher unit, predicts every result byte from
// its own copy of the key store, tables, indices and CRC, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_crc_stream_cipher_unit_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic [1:0] req_tuser,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic [2:0] rsp_tuser,
   input  logic       rsp_tlast,
   output int         errors,
   output int         pending
);

   typedef struct packed {
      logic [7:0] data;
      logic       crc;
      logic       last;
      logic [1:0] status;
   } cipher_out_type;

   cipher_out_type expected_bytes[$];

   logic [7:0]  key_bytes[256];
   logic [7:0]  master_perm[256];
   logic [7:0]  work_perm[256];
   logic [8:0]  key_len_count;
   logic [1:0]  size_code;
   logic        have_key;
   logic [7:0]  pos_i;
   logic [7:0]  pos_j;
   logic        msg_open;
   logic        msg_is_decrypt;
   logic [31:0] crc_acc;
   logic [31:0] held_plain;
   logic [2:0]  held_count;

   function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] r;
      r = acc ^ {24'd0, b};
      repeat (8) r = r[0] ? ({1'b0, r[31:1]} ^ 32'hEDB8_8320) : {1'b0, r[31:1]};
      return r;
   endfunction

   function automatic logic [7:0] next_stream_byte();
      logic [7:0] m;
      logic [7:0] a;
      logic [7:0] b;
      m = 8'((32 << size_code) - 1);
      pos_i = (pos_i + 8'd1) & m;
      pos_j = (pos_j + work_perm[pos_i]) & m;
      a = work_perm[pos_i];
      b = work_perm[pos_j];
      work_perm[pos_i] = b;
      work_perm[pos_j] = a;
      return work_perm[(a + b) & m];
   endfunction

   function automatic void push_out(logic [7:0] d, logic c, logic l, logic [1:0] s);
      cipher_out_type e;
      e = '{data: d, crc: c, last: l, status: s};
      expected_bytes.push_back(e);
   endfunction

   task automatic predict_transfer(input logic [1:0] mode, input logic [7:0] d,
                                   input logic last);
      int          len;
      int          n;
      int          jj;
      logic [7:0]  t;
      logic [31:0] crc_final;
      logic [7:0]  p;
      logic [7:0]  old;
      logic        release_now;
      if (mode == rcc_pkg::MODE_KEY) begin
         msg_open = 1'b0;
         if (key_len_count < 256) key_bytes[key_len_count] = d;
         if (last) begin
            len = int'(key_len_count) + 1;
            if (len == 64 || len == 128 || len == 256) begin
               n = len;
               jj = 0;
               for (int k = 0; k < n; k++) master_perm[k] = 8'(k);
               for (int k = 0; k < n; k++) begin
                  jj = (jj + master_perm[k] + key_bytes[k]) % n;
                  t = master_perm[k];
                  master_perm[k] = master_perm[jj];
                  master_perm[jj] = t;
               end
               size_code = (len == 64) ? rcc_pkg::SIZE_64 :
                           (len == 128) ? rcc_pkg::SIZE_128 : rcc_pkg::SIZE_256;
               have_key = 1'b1;
            end else begin
               size_code = rcc_pkg::SIZE_NONE;
               have_key = 1'b0;
            end
            key_len_count = '0;
         end else if (key_len_count != 9'd511) begin
            key_len_count++;
         end
         return;
      end
      if (mode != rcc_pkg::MODE_ENCRYPT && mode != rcc_pkg::MODE_DECRYPT) return;
      if (!have_key) begin
         push_out(8'd0, 1'b0, last, rcc_pkg::STATUS_NO_KEY);
         return;
      end
      if (!msg_open) begin
         work_perm = master_perm;
         pos_i = '0;
         pos_j = '0;
         crc_acc = '1;
         held_plain = '0;
         held_count = '0;
         msg_is_decrypt = (mode == rcc_pkg::MODE_DECRYPT);
         msg_open = 1'b1;
      end
      if (!msg_is_decrypt) begin
         crc_acc = crc32_step(crc_acc, d);
         push_out(d ^ next_stream_byte(), 1'b0, 1'b0, rcc_pkg::STATUS_OK);
         if (last) begin
            crc_final = ~crc_acc;
            for (int k = 0; k < 4; k++)
               push_out(crc_final[8*k +: 8] ^ next_stream_byte(), 1'b1, k == 3,
                        rcc_pkg::STATUS_OK);
            msg_open = 1'b0;
         end
         return;
      end
      // Decryption keeps the last four plaintext bytes in a delay line.
      p = d ^ next_stream_byte();
      release_now = (held_count >= 3'd4);
      old = held_plain[7:0];
      if (release_now) crc_acc = crc32_step(crc_acc, old);
      held_plain = {p, held_plain[31:8]};
      if (held_count < 3'd4) held_count++;
      if (!last) begin
         if (release_now) push_out(old, 1'b0, 1'b0, rcc_pkg::STATUS_OK);
         return;
      end
      msg_open = 1'b0;
      if (held_count < 3'd4) push_out(8'd0, 1'b0, 1'b1, rcc_pkg::STATUS_TOO_SHORT);
      else push_out(release_now ? old : 8'd0, 1'b0, 1'b1,
                    ((~crc_acc) == held_plain) ? rcc_pkg::STATUS_OK :
                                                 rcc_pkg::STATUS_CRC_BAD);
   endtask

   always @(posedge clock) begin
      cipher_out_type e;
      int             bad;
      bad = 0;
      if (reset) begin
         expected_bytes.delete();
         key_len_count = '0;
         size_code = rcc_pkg::SIZE_NONE;
         have_key = 1'b0;
         pos_i = '0;
         pos_j = '0;
         msg_open = 1'b0;
         msg_is_decrypt = 1'b0;
         crc_acc = '1;
         held_plain = '0;
         held_count = '0;
         errors <= 0;
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready) predict_transfer(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected result transfer: data %h", rsp_tdata);
               bad++;
            end else begin
               e = expected_bytes.pop_front();
               if (rsp_tdata !== e.data) begin
                  $error("result_byte: expected %h, actual %h", e.data, rsp_tdata);
                  bad++;
               end
               if (rsp_tuser[0] !== e.crc) begin
                  $error("is_crc_byte: expected %b, actual %b", e.crc, rsp_tuser[0]);
                  bad++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_out: expected %b, actual %b", e.last, rsp_tlast);
                  bad++;
               end
               if (rsp_tuser[2:1] !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, rsp_tuser[2:1]);
                  bad++;
               end
            end
         end
         errors <= errors + bad;
         pending <= expected_bytes.size();
      end
   end

endmodule

/* verif/rc4_crc_stream_cipher_unit_tb.sv */
// ----------------------------------------------------------------------------
// rc4_crc_stream_cipher_unit_tb
// Drives keys and messages into the cipher unit with random gaps and stalls;
// the checker beside the unit predicts and compares every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_crc_stream_cipher_unit_tb;

   localparam int CYCLE_LIMIT = 600000;
   // The final drain leaves time for a 256-byte key schedule to finish.
   localparam int DRAIN_CYCLES = 1500;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;
   int         errors;
   int         pending;

   // Knobs and counters used by the sender, receiver and watchdog processes.
   bit         no_gaps = 1'b0;
   bit         hold_long = 1'b0;
   logic [7:0] captured[$];
   int         cycle_count = 0;
   int         item_count = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rc4_crc_stream_cipher_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   rc4_crc_stream_cipher_unit_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .errors(errors), .pending(pending)
   );

   // The run is cut off if it takes far longer than the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rc4_crc_stream_cipher_unit test failed");
         $finish;
      end
   end

   // Receiver: a random pause before each transfer, or one long hold-off
   // when asked, so that the unit's output register fills and it stalls.
   initial begin : receiver
      int gap;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_long = 1'b0;
         end
         gap = no_gaps ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         captured.push_back(rsp_tdata);
      end
   end

   // One request transfer. Valid is only lowered when a gap follows, so a
   // back-to-back transfer never gets two assignments in one time step.
   task automatic send_byte(input logic [1:0] mode, input logic [7:0] d, input logic last);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= d;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
   endtask

   task automatic send_key(input int len, input bit fixed, input logic [7:0] fill);
      for (int k = 0; k < len; k++)
         send_byte(rcc_pkg::MODE_KEY, fixed ? fill : 8'($urandom), k == len - 1);
   endtask

   task automatic send_message(input logic [1:0] mode, input int len);
      for (int k = 0; k < len; k++) send_byte(mode, 8'($urandom), k == len - 1);
   endtask

   // Sender pauses until every expected result has arrived.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Encrypts a random message, then replays the ciphertext and its CRC
   // trailer as a decryption; a flipped bit must give a CRC mismatch.
   task automatic round_trip(input int len, input bit corrupt);
      logic [7:0] cipher[$];
      int         flip;
      wait_drained();
      captured.delete();
      send_message(rcc_pkg::MODE_ENCRYPT, len);
      wait_drained();
      cipher = captured;
      if (corrupt && cipher.size() > 0) begin
         flip = $urandom_range(0, cipher.size() - 1);
         cipher[flip] ^= 8'(1 << $urandom_range(0, 7));
      end
      foreach (cipher[k])
         send_byte(rcc_pkg::MODE_DECRYPT, cipher[k], k == cipher.size() - 1);
   endtask

   initial begin : stimulus
      int pick;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: messages before any key exists, and the ignored mode.
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h00, 1'b0);
      send_byte(rcc_pkg::MODE_DECRYPT, 8'hFF, 1'b1);
      send_byte(rcc_pkg::MODE_IGNORED, 8'hA5, 1'b1);
      // A one-byte key is invalid; a 64-byte key of all ones is valid.
      send_key(1, 1'b1, 8'h00);
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h5A, 1'b1);
      send_key(64, 1'b1, 8'hFF);
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h00, 1'b1);
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'hFF, 1'b1);
      // Decryption that is too short, exactly four bytes, and five bytes.
      send_message(rcc_pkg::MODE_DECRYPT, 2);
      send_message(rcc_pkg::MODE_DECRYPT, 4);
      send_message(rcc_pkg::MODE_DECRYPT, 5);
      // Mixed direction: later bytes follow the direction of the first one.
      send_byte(rcc_pkg::MODE_DECRYPT, 8'h11, 1'b0);
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h22, 1'b0);
      send_byte(rcc_pkg::MODE_IGNORED, 8'h33, 1'b0);
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h44, 1'b0);
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h55, 1'b1);
      round_trip(3, 1'b0);

      // Long receiver hold-off while the sender keeps offering bytes.
      hold_long = 1'b1;
      send_message(rcc_pkg::MODE_ENCRYPT, 12);

      while (item_count < 150) begin
         pick = $urandom_range(0, 99);
         no_gaps = ($urandom_range(0, 7) == 0);
         if (pick < 60) begin
            round_trip($urandom_range(1, 4), $urandom_range(0, 3) == 0);
         end else if (pick < 80) begin
            send_message($urandom_range(1, 2), $urandom_range(1, 6));
         end else begin
            // Noise: encrypt, decrypt or ignored mode, any data, any last flag.
            repeat ($urandom_range(1, 4))
               send_byte(2'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
         end
      end
      no_gaps = 1'b0;

      // A key byte abandons an open message; this short key is invalid.
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h66, 1'b0);
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h67, 1'b0);
      send_key(1, 1'b0, 8'h00);
      send_byte(rcc_pkg::MODE_ENCRYPT, 8'h77, 1'b1);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("rc4_crc_stream_cipher_unit test passed");
      end else begin
         $display("rc4_crc_stream_cipher_unit test failed");
      end
      $finish;
   end

endmodule
